/* hw/rtl/camera_view_basis_macros.svh */
// Assertion macros for the camera view basis block.
// Included by the top level; needs no other file.
`ifndef CAMERA_VIEW_BASIS_MACROS_SVH
`define CAMERA_VIEW_BASIS_MACROS_SVH

// same-cycle implication
`define CVB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CVB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cvb_pkg.sv */
// Shared types and constants for the camera view basis block.
// No dependencies.
`default_nettype none

package cvb_pkg;
   localparam int IN_WIDTH      = 24;
   localparam int OUT_FRAC_BITS = 14;
   localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
   localparam int SQ_W          = 2 * IN_WIDTH;
   localparam int ROOT_W        = 64;
   localparam int ROOT_BITS     = ROOT_W / 2;
   localparam int MAG_W         = ROOT_BITS;
   localparam int QUO_BITS      = OUT_FRAC_BITS + 1;
   localparam int DIV_W         = MAG_W + OUT_FRAC_BITS + 1;
   localparam int NORM_LAT      = 5 + ROOT_BITS + 1 + QUO_BITS + 1;
   localparam int CROSS_LAT     = 3;
   localparam int PIPE_LAT      = NORM_LAT + 2 * CROSS_LAT;

   typedef logic signed [IN_WIDTH-1:0]  in_comp_type;
   typedef logic signed [OUT_WIDTH-1:0] unit_type;

   localparam unit_type UNIT_ONE = unit_type'(2 ** OUT_FRAC_BITS);

   typedef struct packed {
      in_comp_type x;
      in_comp_type y;
      in_comp_type z;
   } ivec_type;

   typedef struct packed {
      unit_type x;
      unit_type y;
      unit_type z;
   } uvec_type;

   typedef struct packed {
      in_comp_type target_x;
      in_comp_type target_y;
      in_comp_type target_z;
      in_comp_type up_x;
      in_comp_type up_y;
      in_comp_type up_z;
   } req_type;

   typedef struct packed {
      unit_type right_x;
      unit_type right_y;
      unit_type right_z;
      unit_type upward_x;
      unit_type upward_y;
      unit_type upward_z;
      unit_type forward_x;
      unit_type forward_y;
      unit_type forward_z;
      logic     degenerate;
   } rsp_type;
endpackage

`default_nettype wire

/* hw/rtl/cvb_normalize.sv */
// Pipelined vector normalizer: squares, shift search, root and divide stages.
// Depends on cvb_pkg.
`default_nettype none

module cvb_normalize import cvb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     advance,
   input  wire ivec_type vec_in,
   output uvec_type      unit_out,
   output logic          zero_out
);
   localparam logic [QUO_BITS-1:0] Q_ONE = QUO_BITS'(2 ** OUT_FRAC_BITS);

   logic [IN_WIDTH-1:0] raw [3];

   logic [IN_WIDTH-1:0] mag1_ff [3], mag1_in [3];
   logic [2:0]          neg1_ff, neg1_in;
   logic [SQ_W-1:0]     sq2_ff [3], sq2_in [3];
   logic [IN_WIDTH-1:0] mag2_ff [3];
   logic [2:0]          neg2_ff;
   logic [ROOT_W-1:0]   s3_ff, s3_in;
   logic [MAG_W-1:0]    mag3_ff [3], mag3_in [3];
   logic [2:0]          neg3_ff;
   logic                z3_ff, z3_in;
   logic [ROOT_W-1:0]   s4_ff, s4_in;
   logic [MAG_W-1:0]    mag4_ff [3], mag4_in [3];
   logic [2:0]          neg4_ff;
   logic                z4_ff;
   logic [ROOT_W-1:0]   s5_ff, s5_in;
   logic [MAG_W-1:0]    mag5_ff [3], mag5_in [3];
   logic [2:0]          neg5_ff;
   logic                z5_ff;

   logic [ROOT_W-1:0]   rs_ff [ROOT_BITS], rs_in [ROOT_BITS];
   logic [ROOT_W-1:0]   rr_ff [ROOT_BITS], rr_in [ROOT_BITS];
   logic [MAG_W-1:0]    rm_ff [ROOT_BITS][3], rm_in [ROOT_BITS][3];
   logic [2:0]          rn_ff [ROOT_BITS], rn_in [ROOT_BITS];
   logic                rz_ff [ROOT_BITS], rz_in [ROOT_BITS];

   logic [ROOT_BITS-1:0] len;
   logic [DIV_W-1:0]     d0_ff [3], d0_in [3];
   logic [ROOT_BITS-1:0] l0_ff;
   logic [2:0]           n0_ff;
   logic                 z0_ff;

   logic [DIV_W-1:0]     dd_ff [QUO_BITS][3], dd_in [QUO_BITS][3];
   logic [QUO_BITS-1:0]  dq_ff [QUO_BITS][3], dq_in [QUO_BITS][3];
   logic [ROOT_BITS-1:0] dl_ff [QUO_BITS], dl_in [QUO_BITS];
   logic [2:0]           dn_ff [QUO_BITS], dn_in [QUO_BITS];
   logic                 dz_ff [QUO_BITS], dz_in [QUO_BITS];

   unit_type             u_ff [3], u_in [3];
   logic                 uz_ff;

   assign raw[0] = vec_in.x;
   assign raw[1] = vec_in.y;
   assign raw[2] = vec_in.z;

   // magnitudes, squares, sum of squares
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         neg1_in[c] = raw[c][IN_WIDTH-1];
         mag1_in[c] = raw[c][IN_WIDTH-1] ? IN_WIDTH'(~raw[c] + 1'b1) : raw[c];
         sq2_in[c]  = SQ_W'(mag1_ff[c]) * SQ_W'(mag1_ff[c]);
         mag3_in[c] = MAG_W'(mag2_ff[c]);
      end
      s3_in = ROOT_W'(sq2_ff[0]) + ROOT_W'(sq2_ff[1]) + ROOT_W'(sq2_ff[2]);
      z3_in = (sq2_ff[0] == '0) && (sq2_ff[1] == '0) && (sq2_ff[2] == '0);
   end

   // shift search: coarse steps
   always_comb begin
      logic [ROOT_W-1:0] s;
      logic [MAG_W-1:0]  m [3];
      s = s3_ff;
      m = mag3_ff;
      for (int t = 4; t >= 3; t--) begin
         if ((s >> (ROOT_W - (2 << t))) == '0) begin
            s = s << (2 << t);
            for (int c = 0; c < 3; c++) m[c] = m[c] << (1 << t);
         end
      end
      s4_in   = s;
      mag4_in = m;
   end

   // shift search: fine steps
   always_comb begin
      logic [ROOT_W-1:0] s;
      logic [MAG_W-1:0]  m [3];
      s = s4_ff;
      m = mag4_ff;
      for (int t = 2; t >= 0; t--) begin
         if ((s >> (ROOT_W - (2 << t))) == '0) begin
            s = s << (2 << t);
            for (int c = 0; c < 3; c++) m[c] = m[c] << (1 << t);
         end
      end
      s5_in   = s;
      mag5_in = m;
   end

   // square root, one result bit per stage
   always_comb begin
      logic [ROOT_W-1:0] s, r, b, trial;
      for (int i = 0; i < ROOT_BITS; i++) begin
         if (i == 0) begin
            s        = s5_ff;
            r        = '0;
            rm_in[i] = mag5_ff;
            rn_in[i] = neg5_ff;
            rz_in[i] = z5_ff;
         end else begin
            s        = rs_ff[i-1];
            r        = rr_ff[i-1];
            rm_in[i] = rm_ff[i-1];
            rn_in[i] = rn_ff[i-1];
            rz_in[i] = rz_ff[i-1];
         end
         b     = ROOT_W'(1) << (ROOT_W - 2 - 2 * i);
         trial = r + b;
         if (s >= trial) begin
            rs_in[i] = s - trial;
            rr_in[i] = (r >> 1) + b;
         end else begin
            rs_in[i] = s;
            rr_in[i] = r >> 1;
         end
      end
   end

   assign len = rr_ff[ROOT_BITS-1][ROOT_BITS-1:0];

   // dividend with half divisor for rounding, then restoring division
   always_comb begin
      logic [DIV_W-1:0]     d, den;
      logic [QUO_BITS-1:0]  q;
      logic [ROOT_BITS-1:0] l;
      for (int c = 0; c < 3; c++) begin
         d0_in[c] = (DIV_W'(rm_ff[ROOT_BITS-1][c]) << OUT_FRAC_BITS) + DIV_W'(len >> 1);
      end
      for (int t = 0; t < QUO_BITS; t++) begin
         if (t == 0) begin
            l        = l0_ff;
            dn_in[t] = n0_ff;
            dz_in[t] = z0_ff;
         end else begin
            l        = dl_ff[t-1];
            dn_in[t] = dn_ff[t-1];
            dz_in[t] = dz_ff[t-1];
         end
         dl_in[t] = l;
         den = DIV_W'(l) << (QUO_BITS - 1 - t);
         for (int c = 0; c < 3; c++) begin
            if (t == 0) begin
               d = d0_ff[c];
               q = '0;
            end else begin
               d = dd_ff[t-1][c];
               q = dq_ff[t-1][c];
            end
            if (d >= den) begin
               d = d - den;
               q[QUO_BITS-1-t] = 1'b1;
            end
            dd_in[t][c] = d;
            dq_in[t][c] = q;
         end
      end
   end

   // clamp and apply sign
   always_comb begin
      logic [QUO_BITS-1:0] q;
      for (int c = 0; c < 3; c++) begin
         q = dq_ff[QUO_BITS-1][c];
         if (q > Q_ONE) q = Q_ONE;
         u_in[c] = dn_ff[QUO_BITS-1][c] ? -OUT_WIDTH'(q) : OUT_WIDTH'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
         sq2_ff  <= sq2_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         s3_ff   <= s3_in;
         mag3_ff <= mag3_in;
         neg3_ff <= neg2_ff;
         z3_ff   <= z3_in;
         s4_ff   <= s4_in;
         mag4_ff <= mag4_in;
         neg4_ff <= neg3_ff;
         z4_ff   <= z3_ff;
         s5_ff   <= s5_in;
         mag5_ff <= mag5_in;
         neg5_ff <= neg4_ff;
         z5_ff   <= z4_ff;
         rs_ff   <= rs_in;
         rr_ff   <= rr_in;
         rm_ff   <= rm_in;
         rn_ff   <= rn_in;
         rz_ff   <= rz_in;
         d0_ff   <= d0_in;
         l0_ff   <= len;
         n0_ff   <= rn_ff[ROOT_BITS-1];
         z0_ff   <= rz_ff[ROOT_BITS-1];
         dd_ff   <= dd_in;
         dq_ff   <= dq_in;
         dl_ff   <= dl_in;
         dn_ff   <= dn_in;
         dz_ff   <= dz_in;
         u_ff    <= u_in;
         uz_ff   <= dz_ff[QUO_BITS-1];
      end
   end

   assign unit_out.x = u_ff[0];
   assign unit_out.y = u_ff[1];
   assign unit_out.z = u_ff[2];
   assign zero_out   = uz_ff;
endmodule

`default_nettype wire

/* hw/rtl/cvb_cross.sv */
// Three-stage cross product of two Q1.14 vectors with rounding and clamp.
// Depends on cvb_pkg.
`default_nettype none

module cvb_cross import cvb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     advance,
   input  wire uvec_type a_in,
   input  wire uvec_type b_in,
   output uvec_type      c_out
);
   localparam int PW = 2 * OUT_WIDTH;
   localparam int DW = PW + 1;
   localparam int RW = DW - OUT_FRAC_BITS;
   localparam logic [RW-1:0] R_ONE  = RW'(2 ** OUT_FRAC_BITS);
   localparam logic [DW-1:0] R_HALF = DW'(2 ** (OUT_FRAC_BITS - 1));

   logic signed [PW-1:0] p_ff [6], p_in [6];
   logic signed [DW-1:0] d_ff [3], d_in [3];
   unit_type             r_ff [3], r_in [3];

   always_comb begin
      logic [DW-1:0] mag;
      logic [RW-1:0] rnd;
      p_in[0] = a_in.y * b_in.z;
      p_in[1] = a_in.z * b_in.y;
      p_in[2] = a_in.z * b_in.x;
      p_in[3] = a_in.x * b_in.z;
      p_in[4] = a_in.x * b_in.y;
      p_in[5] = a_in.y * b_in.x;
      for (int c = 0; c < 3; c++) begin
         d_in[c] = DW'(p_ff[2*c]) - DW'(p_ff[2*c+1]);
         mag = d_ff[c][DW-1] ? DW'(-d_ff[c]) : DW'(d_ff[c]);
         rnd = RW'((mag + R_HALF) >> OUT_FRAC_BITS);
         if (rnd > R_ONE) rnd = R_ONE;
         r_in[c] = d_ff[c][DW-1] ? -OUT_WIDTH'(rnd) : OUT_WIDTH'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff <= p_in;
         d_ff <= d_in;
         r_ff <= r_in;
      end
   end

   assign c_out.x = r_ff[0];
   assign c_out.y = r_ff[1];
   assign c_out.z = r_ff[2];
endmodule

`default_nettype wire

/* hw/rtl/camera_view_basis.sv */
// Top level of the camera view basis block: two normalizers, two cross stages,
// output register with skid. Depends on cvb_pkg, cvb_normalize, cvb_cross.
//
// Use:
//   req channel carries one target direction and one up vector (Q7.16) per beat.
//   rsp channel returns the nine view rotation entries (Q1.14) and a
//   degenerate flag, one beat per request beat, in order.
//   A request beat moves on when req_valid is high and req_stall is low;
//   a response beat likewise with rsp_valid and rsp_stall.
//   A beat passes from request to response register through the normalizers
//   (squares, shift search, a 32-stage square root, a 15-stage divider),
//   then each cross product in turn and then the output register.
//   Throughput is one beat per cycle while req_stall is low; each root and
//   quotient bit has its own stage so no unit is shared between beats.
//   Reset clears the valid bits of every stage and of the output and skid
//   registers; their data is left as is.
//   When rsp_stall holds an output beat, one more beat lands in the skid
//   register; the pipeline then freezes and req_stall rises until the skid
//   drains. Nothing in flight is lost or repeated.
`default_nettype none

module camera_view_basis import cvb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
`include "camera_view_basis_macros.svh"

   logic     advance;
   logic     pop;
   ivec_type tvec, pvec;
   uvec_type n_vec, pn_vec, u_vec, v_vec;
   logic     tz, pz;

   logic     valid_ff [PIPE_LAT], valid_in [PIPE_LAT];
   uvec_type nd_ff [2*CROSS_LAT];
   uvec_type ud_ff [CROSS_LAT];
   logic     zd_ff [2*CROSS_LAT];

   rsp_type  fin;
   rsp_type  out_ff, out_in, skid_ff, skid_in;
   logic     out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   assign tvec = '{x: req_data.target_x, y: req_data.target_y, z: req_data.target_z};
   assign pvec = '{x: req_data.up_x, y: req_data.up_y, z: req_data.up_z};

   cvb_normalize u_norm_t (
      .clock    (clock),
      .advance  (advance),
      .vec_in   (tvec),
      .unit_out (n_vec),
      .zero_out (tz)
   );

   cvb_normalize u_norm_p (
      .clock    (clock),
      .advance  (advance),
      .vec_in   (pvec),
      .unit_out (pn_vec),
      .zero_out (pz)
   );

   cvb_cross u_cross_u (
      .clock   (clock),
      .advance (advance),
      .a_in    (pn_vec),
      .b_in    (n_vec),
      .c_out   (u_vec)
   );

   cvb_cross u_cross_v (
      .clock   (clock),
      .advance (advance),
      .a_in    (nd_ff[CROSS_LAT-1]),
      .b_in    (u_vec),
      .c_out   (v_vec)
   );

   always_comb begin
      valid_in[0] = req_valid;
      for (int i = 1; i < PIPE_LAT; i++) valid_in[i] = valid_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nd_ff[0] <= n_vec;
         zd_ff[0] <= tz || pz;
         ud_ff[0] <= u_vec;
         for (int i = 1; i < 2 * CROSS_LAT; i++) begin
            nd_ff[i] <= nd_ff[i-1];
            zd_ff[i] <= zd_ff[i-1];
         end
         for (int i = 1; i < CROSS_LAT; i++) ud_ff[i] <= ud_ff[i-1];
      end
   end

   always_comb begin
      fin = '{
         right_x:    ud_ff[CROSS_LAT-1].x,
         right_y:    ud_ff[CROSS_LAT-1].y,
         right_z:    ud_ff[CROSS_LAT-1].z,
         upward_x:   v_vec.x,
         upward_y:   v_vec.y,
         upward_z:   v_vec.z,
         forward_x:  nd_ff[2*CROSS_LAT-1].x,
         forward_y:  nd_ff[2*CROSS_LAT-1].y,
         forward_z:  nd_ff[2*CROSS_LAT-1].z,
         degenerate: 1'b0
      };
      if (zd_ff[2*CROSS_LAT-1]) begin
         fin            = '0;
         fin.degenerate = 1'b1;
      end
   end

   // output register and skid
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !pop;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_in       = fin;
         out_valid_in = valid_ff[PIPE_LAT-1];
      end else if (valid_ff[PIPE_LAT-1]) begin
         skid_in       = fin;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `CVB_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid holds a beat while output is empty")
   `CVB_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, valid_ff[0], "accepted beat missing from first stage")
   `CVB_ASSERT_NOW(a_degenerate_zero, clock, reset, rsp_valid && rsp_data.degenerate, (rsp_data.right_x == '0) && (rsp_data.upward_y == '0) && (rsp_data.forward_z == '0), "degenerate beat has nonzero entries")
   `CVB_ASSERT_NOW(a_unit_range, clock, reset, rsp_valid, (rsp_data.forward_x <= UNIT_ONE) && (rsp_data.forward_x >= -UNIT_ONE), "forward entry out of unit range")
endmodule

`default_nettype wire

/* dv/tb_camera_view_basis.sv */
// Testbench for camera_view_basis: drives target and up vectors, predicts the
// view rotation rows and degenerate flag, and checks every response beat.
// Depends on cvb_pkg and the camera_view_basis RTL.
`timescale 1ns / 1ps

module tb_camera_view_basis;
   import cvb_pkg::*;

   localparam int ONE_Q = 1 << OUT_FRAC_BITS;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type basis_due[$];
   int      mismatches = 0;
   bit      steady = 1'b0;

   camera_view_basis dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned len_sq(longint a, longint b, longint c);
      return mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c);
   endfunction

   function automatic void unit_vec(input longint c[3], input longint unsigned s,
                                    output longint o[3]);
      int k;
      longint unsigned len;
      longint unsigned q;
      k = 0;
      while (s < (64'd1 << 62)) begin
         s = s << 2;
         k++;
      end
      len = root_floor(s);
      for (int i = 0; i < 3; i++) begin
         q = (((mag(c[i]) << k) << OUT_FRAC_BITS) + (len >> 1)) / len;
         if (q > ONE_Q) q = ONE_Q;
         o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic longint to_unit(longint p);
      longint r;
      r = longint'((mag(p) + (64'd1 << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS);
      if (r > ONE_Q) r = ONE_Q;
      return p < 0 ? -r : r;
   endfunction

   function automatic void cross_prod(input longint a[3], input longint b[3],
                                      output longint o[3]);
      o[0] = to_unit(a[1] * b[2] - a[2] * b[1]);
      o[1] = to_unit(a[2] * b[0] - a[0] * b[2]);
      o[2] = to_unit(a[0] * b[1] - a[1] * b[0]);
   endfunction

   function automatic rsp_type view_basis(req_type r);
      longint t[3], p[3], n[3], pn[3], u[3], v[3];
      longint unsigned st, sp;
      rsp_type e;
      e = '0;
      t = '{longint'(r.target_x), longint'(r.target_y), longint'(r.target_z)};
      p = '{longint'(r.up_x), longint'(r.up_y), longint'(r.up_z)};
      st = len_sq(t[0], t[1], t[2]);
      sp = len_sq(p[0], p[1], p[2]);
      if (st == 0 || sp == 0) begin
         e.degenerate = 1'b1;
         return e;
      end
      unit_vec(t, st, n);
      unit_vec(p, sp, pn);
      cross_prod(pn, n, u);
      cross_prod(n, u, v);
      e.right_x = unit_type'(u[0]);
      e.right_y = unit_type'(u[1]);
      e.right_z = unit_type'(u[2]);
      e.upward_x = unit_type'(v[0]);
      e.upward_y = unit_type'(v[1]);
      e.upward_z = unit_type'(v[2]);
      e.forward_x = unit_type'(n[0]);
      e.forward_y = unit_type'(n[1]);
      e.forward_z = unit_type'(n[2]);
      return e;
   endfunction

   function automatic bit idle_now();
      return !steady && ($urandom_range(99) < 23);
   endfunction

   task automatic send_beat(req_type r);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      basis_due.push_back(view_basis(r));
   endtask

   function automatic in_comp_type rand_comp();
      case ($urandom_range(5))
         0: return in_comp_type'($urandom);
         1: return in_comp_type'($signed($urandom_range(16)) - 8);
         2: return $urandom_range(1) ? in_comp_type'(-(1 << (IN_WIDTH - 1)))
                                     : in_comp_type'((1 << (IN_WIDTH - 1)) - 1);
         3: return in_comp_type'(0);
         default: return in_comp_type'($signed($urandom_range(262144)) - 131072);
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int s;
      r.target_x = rand_comp();
      r.target_y = rand_comp();
      r.target_z = rand_comp();
      r.up_x = rand_comp();
      r.up_y = rand_comp();
      r.up_z = rand_comp();
      case ($urandom_range(9))
         0: begin
            s = $urandom_range(4) - 2;
            r.up_x = in_comp_type'(longint'(r.target_x) * s);
            r.up_y = in_comp_type'(longint'(r.target_y) * s);
            r.up_z = in_comp_type'(longint'(r.target_z) * s);
         end
         1: r.up_x = r.target_x;
         default: ;
      endcase
      return r;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (basis_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      in_comp_type mx, mn;
      req_type r;
      mx = in_comp_type'((1 << (IN_WIDTH - 1)) - 1);
      mn = in_comp_type'(-(1 << (IN_WIDTH - 1)));
      send_beat('{0, 0, 0, 0, 0, 0});
      send_beat('{65536, 0, 0, 0, 0, 0});
      send_beat('{0, 0, 0, 0, 65536, 0});
      send_beat('{0, 0, 65536, 0, 65536, 0});
      send_beat('{0, 0, -65536, 0, 65536, 0});
      send_beat('{65536, 0, 0, 0, 0, 65536});
      send_beat('{65536, 65536, 0, -65536, -65536, 0});
      send_beat('{0, 65536, 0, 0, 65536, 0});
      send_beat('{mx, mx, mx, mn, mn, mn});
      send_beat('{mn, mn, mn, mx, mx, mx});
      send_beat('{mn, 0, 0, 0, mn, 0});
      send_beat('{1, 0, 0, 0, 1, 0});
      send_beat('{1, 1, 1, -1, 0, 1});
      send_beat('{-1, -1, -1, mx, 0, mn});
      send_beat('{mx, 1, -1, 1, mx, 0});
      send_beat('{3, 4, 0, 0, 0, -5});
      send_beat('{-8388608, 8388607, 1, 5, -7, 11});
      r = '{in_comp_type'(24'h555555), in_comp_type'(24'haaaaaa), 1, 2, 3,
            in_comp_type'(24'h2aaaab)};
      send_beat(r);
      send_beat(~r);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         steady = (i >= 200 && i < 300);
         send_beat(rand_req());
      end
      steady = 1'b0;
   endtask

   task automatic test_back_to_back(int count);
      steady = 1'b1;
      for (int i = 0; i < count; i++) send_beat(rand_req());
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= idle_now();
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (basis_due.size() == 0) begin
            $error("response beat with nothing expected");
            mismatches++;
         end else begin
            e = basis_due.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (rsp_data.right_x !== e.right_x)
                  $error("right_x exp %0d got %0d", e.right_x, rsp_data.right_x);
               if (rsp_data.right_y !== e.right_y)
                  $error("right_y exp %0d got %0d", e.right_y, rsp_data.right_y);
               if (rsp_data.right_z !== e.right_z)
                  $error("right_z exp %0d got %0d", e.right_z, rsp_data.right_z);
               if (rsp_data.upward_x !== e.upward_x)
                  $error("upward_x exp %0d got %0d", e.upward_x, rsp_data.upward_x);
               if (rsp_data.upward_y !== e.upward_y)
                  $error("upward_y exp %0d got %0d", e.upward_y, rsp_data.upward_y);
               if (rsp_data.upward_z !== e.upward_z)
                  $error("upward_z exp %0d got %0d", e.upward_z, rsp_data.upward_z);
               if (rsp_data.forward_x !== e.forward_x)
                  $error("forward_x exp %0d got %0d", e.forward_x, rsp_data.forward_x);
               if (rsp_data.forward_y !== e.forward_y)
                  $error("forward_y exp %0d got %0d", e.forward_y, rsp_data.forward_y);
               if (rsp_data.forward_z !== e.forward_z)
                  $error("forward_z exp %0d got %0d", e.forward_z, rsp_data.forward_z);
               if (rsp_data.degenerate !== e.degenerate)
                  $error("degenerate exp %0d got %0d", e.degenerate,
                         rsp_data.degenerate);
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_random(700);
      wait_drained();
      test_back_to_back(200);
      wait_drained();
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (mismatches == 0 && basis_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

/* camera_view_basis.f */
+incdir+hw/rtl
hw/rtl/cvb_pkg.sv
hw/rtl/cvb_normalize.sv
hw/rtl/cvb_cross.sv
hw/rtl/camera_view_basis.sv
dv/tb_camera_view_basis.sv
